// ----- design/pcbp_pkg.sv -----
// shared types and constants of the prefix code bit packer
// no dependencies; used by pcbp_in_if, pcbp_cfg_if and all modules
package pcbp_pkg;

	localparam int SYMBOLS  = 256;
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int BYTES_MAX = 4;

	// longest code or raw prefix, in bits
	localparam logic [LEN_W-1:0] LEN_CAP = 6'd32;

	// item kinds
	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_PREFIX = 2'd2,
		KIND_FLUSH  = 2'd3
	} kind_t;

	// register indexes
	typedef enum logic {
		REG_KEY  = 1'b0,
		REG_SEED = 1'b1
	} reg_idx_t;

	// one code table entry as read back
	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} tbl_rd_t;

endpackage

// ----- design/pcbp_in_if.sv -----
// input item channel of the prefix code bit packer
// depends on pcbp_pkg
interface pcbp_in_if;
	logic                     valid;
	logic                     ready;
	pcbp_pkg::kind_t          kind;
	logic [7:0]               symbol;
	logic [5:0]               bit_count;
	logic [31:0]              bits;

	modport source (output valid, kind, symbol, bit_count, bits, input ready);
	modport sink (input valid, kind, symbol, bit_count, bits, output ready);
endinterface

// ----- design/pcbp_out_if.sv -----
// result channel of the prefix code bit packer
// no dependencies
interface pcbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       is_final;
	logic [2:0] pad_count;
	logic [7:0] checksum;
	logic       last;

	modport source (output valid, out_byte, byte_valid, is_final, pad_count, checksum, last,
		input ready);
	modport sink (input valid, out_byte, byte_valid, is_final, pad_count, checksum, last,
		output ready);
endinterface

// ----- design/pcbp_cfg_if.sv -----
// register write channel of the prefix code bit packer
// depends on pcbp_pkg
interface pcbp_cfg_if;
	logic                 valid;
	logic                 ready;
	pcbp_pkg::reg_idx_t   index;
	logic [7:0]           data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/prefix_code_bit_packer_unit.sv -----
// top level of the prefix code bit packer: bit buffer, byte drain and output queue
// depends on pcbp_pkg, pcbp_in_if, pcbp_out_if, pcbp_cfg_if, pcbp_code_table
//
// usage:
//   sym_in  carries items: load a code table entry, encode a data symbol,
//           append raw prefix bits, or flush. A word is taken when valid and ready.
//   byte_out carries result words: one per completed byte (up to four per item),
//           or one final word on flush with pad count and checksum; last marks
//           the final word of an item. Loads and items that finish no byte give none.
//   cfg     writes key_byte (index 0) or checksum_seed (index 1); always ready.
//           Write only while the block is idle; a seed write also reloads the checksum.
// timing:
//   an item is registered together with its code table read, then packed into a
//   result group when the group is free; the group registers then offer its first word.
//   One item per cycle is taken while each gives at most one word and byte_out is ready;
//   an item with n bytes holds the group, one word per cycle on byte_out while it is ready.
// reset:
//   all code lengths read as zero, the bit buffer empties, key, seed and checksum
//   clear. When byte_out stalls, the group holds and sym_in stops once the
//   registered item needs the group.
module prefix_code_bit_packer_unit (
	input  logic        clk,
	input  logic        arst_n,
	pcbp_in_if.sink     sym_in,
	pcbp_out_if.source  byte_out,
	pcbp_cfg_if.sink    cfg
);
	import pcbp_pkg::*;

	// configuration and stream state
	logic [7:0] key_q;
	logic [7:0] seed_q;
	logic [7:0] run_sum_q;
	logic [6:0] buf_q;
	logic [2:0] fill_q;

	// item register
	logic              s1_valid_q;
	kind_t             kind_s1;
	logic [LEN_W-1:0]  cnt_s1;
	logic [CODE_W-1:0] bits_s1;
	tbl_rd_t           tbl;

	// result group
	logic             grp_busy_q;
	logic [7:0]       grp_byte_q [BYTES_MAX];
	logic [2:0]       grp_cnt_q;
	logic [1:0]       idx_q;
	logic             grp_final_q;
	logic             grp_bvalid_q;
	logic [2:0]       grp_pad_q;
	logic [7:0]       grp_sum_q;

	logic             in_acc;
	logic             out_acc;
	logic             grp_done;
	logic             grp_free;
	logic             s1_go;
	logic             has_res;
	logic [LEN_W-1:0] cnt_in;

	logic [LEN_W-1:0] app_n;
	logic [CODE_W-1:0] app_val;
	logic [38:0]      cat;
	logic [LEN_W-1:0] fill_sum;
	logic [39:0]      win;
	logic [2:0]       nbytes;
	logic [7:0]       drain_byte [BYTES_MAX];
	logic [7:0]       drain_sum;
	logic [7:0]       keep_mask;
	logic [2:0]       fl_pad;
	logic [7:0]       fl_byte;

	// handshakes
	assign in_acc   = sym_in.valid && sym_in.ready;
	assign out_acc  = byte_out.valid && byte_out.ready;
	assign grp_done = out_acc && byte_out.last;
	assign grp_free = !grp_busy_q || grp_done;
	assign s1_go    = s1_valid_q && (!has_res || grp_free);
	assign sym_in.ready = !s1_valid_q || s1_go;
	assign cfg.ready    = 1'b1;

	// length saturation
	assign cnt_in = (sym_in.bit_count > LEN_CAP) ? LEN_CAP : sym_in.bit_count;

	pcbp_code_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_acc && sym_in.kind == KIND_LOAD),
		.wr_addr (sym_in.symbol),
		.wr_bits (sym_in.bits),
		.wr_len  (cnt_in),
		.rd_en   (in_acc),
		.rd_addr (sym_in.symbol),
		.rd      (tbl)
	);

	// item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sym_in.ready) begin
			s1_valid_q <= sym_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= sym_in.kind;
			cnt_s1  <= cnt_in;
			bits_s1 <= sym_in.bits;
		end
	end

	// bits appended by the registered item
	always_comb begin
		case (kind_s1)
			KIND_DATA:   app_n = tbl.len;
			KIND_PREFIX: app_n = cnt_s1;
			default:     app_n = '0;
		endcase
		app_val = (kind_s1 == KIND_DATA) ? tbl.bits : bits_s1;
	end

	// append and left-align so whole bytes sit at the top of the window
	always_comb begin
		cat = (39'(buf_q) << app_n) | (39'(app_val) & ((39'd1 << app_n) - 39'd1));
		fill_sum = LEN_W'(fill_q) + app_n;
		win = 40'(cat) << (6'd40 - fill_sum);
		nbytes = fill_sum[5:3];
		keep_mask = (8'd1 << fill_sum[2:0]) - 8'd1;
	end

	// drained bytes and their checksum
	always_comb begin
		drain_sum = run_sum_q;
		for (int i = 0; i < BYTES_MAX; i++) begin
			drain_byte[i] = win[39 - 8*i -: 8];
			if (3'(i) < nbytes) begin
				drain_sum = drain_sum ^ drain_byte[i];
			end
		end
	end

	// flush padding
	assign fl_pad  = 3'(4'd8 - 4'(fill_q));
	assign fl_byte = 8'({1'b0, buf_q} << fl_pad);

	assign has_res = (kind_s1 == KIND_FLUSH) || (nbytes != 3'd0);

	// stream state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q     <= '0;
			fill_q    <= '0;
			run_sum_q <= '0;
			key_q     <= '0;
			seed_q    <= '0;
		end else begin
			if (s1_go) begin
				if (kind_s1 == KIND_FLUSH) begin
					buf_q     <= '0;
					fill_q    <= '0;
					run_sum_q <= seed_q;
				end else begin
					buf_q     <= cat[6:0] & keep_mask[6:0];
					fill_q    <= fill_sum[2:0];
					run_sum_q <= drain_sum;
				end
			end
			if (cfg.valid) begin
				case (cfg.index)
					REG_KEY: key_q <= cfg.data;
					REG_SEED: begin
						seed_q    <= cfg.data;
						run_sum_q <= cfg.data;
					end
					default: ;
				endcase
			end
		end
	end

	// result group control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_busy_q <= 1'b0;
			idx_q      <= '0;
		end else if (s1_go && has_res) begin
			grp_busy_q <= 1'b1;
			idx_q      <= '0;
		end else if (grp_done) begin
			grp_busy_q <= 1'b0;
			idx_q      <= '0;
		end else if (out_acc) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// result group payload
	always_ff @(posedge clk) begin
		if (s1_go && has_res) begin
			if (kind_s1 == KIND_FLUSH) begin
				grp_cnt_q     <= 3'd1;
				grp_final_q   <= 1'b1;
				grp_bvalid_q  <= (fill_q != 3'd0);
				grp_pad_q     <= (fill_q != 3'd0) ? fl_pad : 3'd0;
				grp_sum_q     <= (fill_q != 3'd0) ? (run_sum_q ^ fl_byte) : run_sum_q;
				grp_byte_q[0] <= (fill_q != 3'd0) ? (fl_byte ^ key_q) : 8'd0;
				for (int i = 1; i < BYTES_MAX; i++) begin
					grp_byte_q[i] <= 8'd0;
				end
			end else begin
				grp_cnt_q    <= nbytes;
				grp_final_q  <= 1'b0;
				grp_bvalid_q <= 1'b1;
				grp_pad_q    <= 3'd0;
				grp_sum_q    <= 8'd0;
				for (int i = 0; i < BYTES_MAX; i++) begin
					grp_byte_q[i] <= drain_byte[i] ^ key_q;
				end
			end
		end
	end

	// output word
	assign byte_out.valid      = grp_busy_q;
	assign byte_out.out_byte   = grp_byte_q[idx_q];
	assign byte_out.byte_valid = grp_bvalid_q;
	assign byte_out.is_final   = grp_final_q;
	assign byte_out.pad_count  = grp_pad_q;
	assign byte_out.checksum   = grp_sum_q;
	assign byte_out.last       = ((3'(idx_q) + 3'd1) == grp_cnt_q);

endmodule

// ----- design/pcbp_code_table.sv -----
// per-symbol code table: code bits and length memories with registered read
// lengths read as zero until an entry is loaded; depends on pcbp_pkg
module pcbp_code_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pcbp_pkg::SYM_W-1:0]          wr_addr,
	input  logic [pcbp_pkg::CODE_W-1:0]         wr_bits,
	input  logic [pcbp_pkg::LEN_W-1:0]          wr_len,
	input  logic                                rd_en,
	input  logic [pcbp_pkg::SYM_W-1:0]          rd_addr,
	output pcbp_pkg::tbl_rd_t                   rd
);
	import pcbp_pkg::*;

	logic [CODE_W-1:0] bits_mem [SYMBOLS];
	logic [LEN_W-1:0]  len_mem [SYMBOLS];
	logic [SYMBOLS-1:0] loaded_q;
	logic [CODE_W-1:0] rd_bits_q;
	logic [LEN_W-1:0]  rd_len_q;

	// entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (wr_en) begin
			loaded_q[wr_addr] <= 1'b1;
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bits_mem[wr_addr] <= wr_bits;
			len_mem[wr_addr]  <= wr_len;
		end
	end

	// registered reads, unloaded entries give zero length
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_bits_q <= bits_mem[rd_addr];
			rd_len_q  <= loaded_q[rd_addr] ? len_mem[rd_addr] : '0;
		end
	end

	assign rd.bits = rd_bits_q;
	assign rd.len  = rd_len_q;

endmodule
